/* hw/rtl/ppd_pkg.sv */
package ppd_pkg;

    localparam int FIELD_W   = 16;
    localparam int ACCEPT_W  = 17;
    localparam int REPOL_W   = 16;
    localparam int HIDDEN_W  = 31;
    localparam int CODE_W    = 2;
    localparam int ELAPSED_W = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam int DEF_ANGLE_BITS     = 16;
    localparam int DEF_ORDINARY_DELAY = 0;
    localparam int DEF_EXTRA_DELAY    = 0;
    localparam int DEF_STAGE_DELAY    = 0;

    localparam logic [ELAPSED_W-1:0] TIME_MAX = '1;

    localparam logic [ACCEPT_W-1:0] RST_ACCEPT = ACCEPT_W'(65536);
    localparam logic [REPOL_W-1:0]  RST_REPOL  = REPOL_W'(32768);
    localparam logic [HIDDEN_W-1:0] RST_HIDDEN = HIDDEN_W'(1073741824);

    localparam logic [CODE_W-1:0] DETECT_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] DETECT_ORDINARY = 2'd1;
    localparam logic [CODE_W-1:0] DETECT_EXTRA    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLARIZER_ANGLE = 3'd0,
        CFG_ORD_ACCEPT      = 3'd1,
        CFG_ORD_REPOL       = 3'd2,
        CFG_ORD_HIDDEN      = 3'd3,
        CFG_EXT_ACCEPT      = 3'd4,
        CFG_EXT_REPOL       = 3'd5,
        CFG_EXT_HIDDEN      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] polarization;
        logic [FIELD_W-1:0] hidden_q;
        logic [FIELD_W-1:0] hidden_r;
        logic [FIELD_W-1:0] random_draw;
    } t_photon;

    typedef struct packed {
        logic [CODE_W-1:0]    detect_code;
        logic [ELAPSED_W-1:0] elapsed_time;
    } t_detect;

endpackage

/* hw/rtl/ppd_in_if.sv */
interface ppd_in_if import ppd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_photon data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ppd_out_if.sv */
interface ppd_out_if import ppd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_detect data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/polarizer_photon_detect.sv */
// Channel   Dir  Payload                                            Handshake
// i_in      in   polarization, hidden_q, hidden_r, random_draw     valid/ready
// o_out     out  detect_code, elapsed_time                         valid/ready
// i_cfg_*   in   register index, write data                        write enable
//
// Two register stages: photon register, then result register.
// One photon per cycle sustained while o_out is ready; the angle math and
// the q*(N-q) multiply sit between the two registers.
// A stalled result holds; an empty photon register still fills behind it.
// Synchronous active-low reset empties both stages and loads register defaults.
module polarizer_photon_detect import ppd_pkg::*; #(
    parameter int ANGLE_BITS     = DEF_ANGLE_BITS,
    parameter int ORDINARY_DELAY = DEF_ORDINARY_DELAY,
    parameter int EXTRA_DELAY    = DEF_EXTRA_DELAY,
    parameter int STAGE_DELAY    = DEF_STAGE_DELAY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ppd_in_if.sink                i_in,
    ppd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = ANGLE_BITS;
    localparam int EW = AW + 4;
    localparam int PW = 2 * AW + 1;
    localparam int HW = (PW > HIDDEN_W) ? PW : HIDDEN_W;
    localparam int CW = (AW > REPOL_W) ? AW : REPOL_W;
    localparam int TW = CW + 2;

    localparam logic [AW:0]   N_FULL    = {1'b1, {AW{1'b0}}};
    localparam logic [AW-1:0] HALF_N    = AW'(1) << (AW - 1);
    localparam logic [AW-1:0] QUARTER_N = AW'(1) << (AW - 2);
    localparam logic [EW-1:0] THREE_N   = EW'(3) << AW;
    localparam logic [EW-1:0] SIX_N     = EW'(6) << AW;

    logic [FIELD_W-1:0]  r_angle;
    logic [ACCEPT_W-1:0] r_ord_accept, r_ext_accept;
    logic [REPOL_W-1:0]  r_ord_repol, r_ext_repol;
    logic [HIDDEN_W-1:0] r_ord_hidden, r_ext_hidden;

    logic    r_in_valid;
    t_photon r_in;
    logic    r_out_valid;
    t_detect r_out;
    t_detect n_out;

    logic en_out, en_in;

    logic [AW-1:0] p_m, q_m, r_m, pa_m, d, rp;
    logic [AW:0]   q_comp;
    logic [PW-1:0] hid_prod;
    logic [EW-1:0] e;
    logic          is_extra, detected;
    logic [ACCEPT_W-1:0] sel_accept;
    logic [REPOL_W-1:0]  sel_repol;
    logic [HIDDEN_W-1:0] sel_hidden;
    logic [TW-1:0]       t_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle      <= '0;
            r_ord_accept <= RST_ACCEPT;
            r_ord_repol  <= RST_REPOL;
            r_ord_hidden <= RST_HIDDEN;
            r_ext_accept <= RST_ACCEPT;
            r_ext_repol  <= RST_REPOL;
            r_ext_hidden <= RST_HIDDEN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLARIZER_ANGLE: r_angle      <= i_cfg_data[FIELD_W-1:0];
                CFG_ORD_ACCEPT:      r_ord_accept <= i_cfg_data[ACCEPT_W-1:0];
                CFG_ORD_REPOL:       r_ord_repol  <= i_cfg_data[REPOL_W-1:0];
                CFG_ORD_HIDDEN:      r_ord_hidden <= i_cfg_data[HIDDEN_W-1:0];
                CFG_EXT_ACCEPT:      r_ext_accept <= i_cfg_data[ACCEPT_W-1:0];
                CFG_EXT_REPOL:       r_ext_repol  <= i_cfg_data[REPOL_W-1:0];
                CFG_EXT_HIDDEN:      r_ext_hidden <= i_cfg_data[HIDDEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance each stage when the one ahead is empty or draining
    assign en_out      = !r_out_valid || o_out.ready;
    assign en_in       = !r_in_valid || en_out;
    assign i_in.ready  = en_in;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_in.valid;
            end
            if (en_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (en_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        p_m  = AW'(r_in.polarization);
        q_m  = AW'(r_in.hidden_q);
        r_m  = AW'(r_in.hidden_r);
        pa_m = AW'(r_angle);
        d    = p_m - pa_m;
        e    = EW'(d) * EW'(6) + EW'({q_m, 1'b0}) + EW'(r_m);

        if (!d[AW-1]) begin
            is_extra = (e >= THREE_N);
            rp       = is_extra ? (HALF_N - d) : d;
        end else begin
            is_extra = (e < SIX_N);
            rp       = is_extra ? (d - HALF_N) : (AW'(0) - d);
        end

        q_comp   = N_FULL - {1'b0, q_m};
        hid_prod = PW'(q_m) * PW'(q_comp);

        if (is_extra) begin
            sel_accept = r_ext_accept;
            sel_repol  = r_ext_repol;
            sel_hidden = r_ext_hidden;
            t_sum      = TW'(rp) + TW'(EXTRA_DELAY);
        end else begin
            sel_accept = r_ord_accept;
            sel_repol  = r_ord_repol;
            sel_hidden = r_ord_hidden;
            t_sum      = TW'(rp) + TW'(ORDINARY_DELAY);
        end
        if (rp >= QUARTER_N) begin
            t_sum = t_sum + TW'(STAGE_DELAY);
        end

        detected = ({1'b0, r_in.random_draw} < sel_accept)
                && (CW'(rp) <= CW'(sel_repol))
                && (HW'(hid_prod) <= HW'(sel_hidden));

        if (detected) begin
            n_out.detect_code  = is_extra ? DETECT_EXTRA : DETECT_ORDINARY;
            n_out.elapsed_time = (t_sum > TW'(TIME_MAX)) ? TIME_MAX
                                                         : t_sum[ELAPSED_W-1:0];
        end else begin
            n_out.detect_code  = DETECT_NONE;
            n_out.elapsed_time = '0;
        end
    end

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.detect_code == DETECT_NONE)
                      || (r_out.detect_code == DETECT_ORDINARY)
                      || (r_out.detect_code == DETECT_EXTRA)))
        else $error("illegal detect code");

    a_undetected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.detect_code == DETECT_NONE)) |->
            (r_out.elapsed_time == '0))
        else $error("undetected photon with nonzero time");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("request taken while both stages are full and stalled");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted request lost from photon register");

    a_drain_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && en_out) |=> r_out_valid)
        else $error("photon register drained without a result");

endmodule
